@@ rtl/stream_find_and_replace_macros.svh @@
// Assertion helpers used by stream_find_and_replace.sv.
`ifndef STREAM_FIND_AND_REPLACE_MACROS_SVH
`define STREAM_FIND_AND_REPLACE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SFR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define SFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ rtl/sfr_pkg.sv @@
package sfr_pkg;

  // Configuration port
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int LEN_W       = 4;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_PATTERN     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_LENGTH      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_TEXT   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  // Per-cell controls from the sequencer
  typedef struct packed {
    logic append;  // load the incoming text byte
    logic shift;   // take the byte of the right-hand neighbor
  } cell_ctl_t;

  // Per-cell compare results
  typedef struct packed {
    logic eq_own;   // held byte equals pattern byte at this position
    logic eq_prev;  // held byte equals pattern byte one position lower
  } cell_stat_t;

endpackage

@@ rtl/sfr_cell.sv @@
module sfr_cell
  import sfr_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctl_t  ctl_i,
  input  logic [7:0] text_byte_i,
  input  logic [7:0] next_byte_i,
  input  logic [7:0] pat_own_i,
  input  logic [7:0] pat_prev_i,
  output logic [7:0] byte_o,
  output cell_stat_t stat_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  // Held byte: load new text, or move one place toward the head
  always_comb begin
    byte_d = byte_q;
    if (ctl_i.append) begin
      byte_d = text_byte_i;
    end else if (ctl_i.shift) begin
      byte_d = next_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // Compare against this position and the one it moves into on a shift
  assign stat_o.eq_own  = (byte_q == pat_own_i);
  assign stat_o.eq_prev = (byte_q == pat_prev_i);
  assign byte_o         = byte_q;

endmodule

@@ rtl/stream_find_and_replace.sv @@
// Streaming find-and-replace on a byte stream.
// Input channel: in_valid_i / in_stall_o with text_byte_i and end_of_text_i;
// a transfer happens when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with out_byte_o and run_last_o;
// run_last_o marks the final output byte caused by one input item.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 pattern, 1 pattern length, 2 replacement, 3 replacement length); write
// only while the block is idle.
// Held bytes live in a row of MAX_SEARCH cells; a release pops the head
// cell and every cell takes its neighbor's byte in the same cycle.
// Timing: an item is taken in ST_IDLE; the sequencer then emits one output
// byte per cycle while the output channel is not stalled, with a compare
// state (ST_CHECK) when the byte enters the hold row. Each output byte
// passes from the sequencer through the output register to out_valid_o.
// in_stall_o stays high until the item's last byte sits in the output reg.
// A stalled receiver holds the sequencer in its emitting states; the output register holds.
// Reset empties the hold row, clears the configuration registers to zero
// (empty pattern, so bytes pass through) and drops out_valid_o.
`include "stream_find_and_replace_macros.svh"

module stream_find_and_replace
  import sfr_pkg::*;
#(
  parameter int MAX_SEARCH  = 8,
  parameter int MAX_REPLACE = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             text_byte_i,
  input  logic                   end_of_text_i,
  // output channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             out_byte_o,
  output logic                   run_last_o
);

  localparam int CntW = $clog2(MAX_SEARCH + 1);
  localparam int RepW = (MAX_REPLACE > 1) ? $clog2(MAX_REPLACE) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_POP   = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_BYTE  = 3'd4;
  localparam logic [2:0] ST_REPL  = 3'd5;

  // Configuration registers
  logic [MAX_SEARCH*8-1:0]  pat_q;
  logic [LEN_W-1:0]         slen_q;
  logic [MAX_REPLACE*8-1:0] rep_q;
  logic [LEN_W-1:0]         rlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      slen_q <= '0;
      rep_q  <= '0;
      rlen_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SEARCH_PATTERN:     pat_q  <= cfg_data_i[MAX_SEARCH*8-1:0];
        CFG_SEARCH_LENGTH:      slen_q <= cfg_data_i[LEN_W-1:0];
        CFG_REPLACEMENT_TEXT:   rep_q  <= cfg_data_i[MAX_REPLACE*8-1:0];
        CFG_REPLACEMENT_LENGTH: rlen_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturated lengths
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] rlen;
  assign len  = (slen_q > LEN_W'(MAX_SEARCH)) ? LEN_W'(MAX_SEARCH) : slen_q;
  assign rlen = (rlen_q > LEN_W'(MAX_REPLACE)) ? LEN_W'(MAX_REPLACE) : rlen_q;

  // Sequencer state
  logic [2:0]      st_q, st_d;
  logic [CntW-1:0] count_q, count_d;
  logic            tail_q, tail_d;
  logic [7:0]      byte_q, byte_d;
  logic [RepW-1:0] ridx_q, ridx_d;

  logic       in_accept;
  logic       slot_free;
  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_last;
  logic       do_append;
  logic       do_shift;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  // Hold row
  logic [7:0]            cell_byte [MAX_SEARCH];
  logic [MAX_SEARCH-1:0] eq_own;
  logic [MAX_SEARCH-1:0] eq_prev;
  logic [MAX_SEARCH-1:0] held_mask;
  logic [MAX_SEARCH-1:0] rest_mask;
  logic                  prefix_own;
  logic                  rest_ok;

  for (genvar i = 0; i < MAX_SEARCH; i++) begin : g_cell
    cell_ctl_t  ctl;
    cell_stat_t stat;
    logic [7:0] next_byte;
    logic [7:0] pat_prev;

    if (i == MAX_SEARCH - 1) begin : g_tail
      assign next_byte = 8'h00;
    end else begin : g_mid
      assign next_byte = cell_byte[i+1];
    end

    if (i == 0) begin : g_head
      assign pat_prev = 8'h00;
    end else begin : g_body
      assign pat_prev = pat_q[(i-1)*8 +: 8];
    end

    assign ctl.append = do_append && (count_q == CntW'(i));
    assign ctl.shift  = do_shift;

    sfr_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .text_byte_i (text_byte_i),
      .next_byte_i (next_byte),
      .pat_own_i   (pat_q[i*8 +: 8]),
      .pat_prev_i  (pat_prev),
      .byte_o      (cell_byte[i]),
      .stat_o      (stat)
    );

    assign eq_own[i]    = stat.eq_own;
    assign eq_prev[i]   = stat.eq_prev;
    assign held_mask[i] = (CntW'(i) < count_q);
    assign rest_mask[i] = (i != 0) && held_mask[i];
  end

  // Held bytes are a prefix of the pattern; same for the row after one pop
  assign prefix_own = &(eq_own | ~held_mask);
  assign rest_ok    = &(eq_prev | ~rest_mask);

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (st_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Sequencer
  always_comb begin
    st_d      = st_q;
    count_d   = count_q;
    tail_d    = tail_q;
    byte_d    = byte_q;
    ridx_d    = ridx_q;
    emit      = 1'b0;
    emit_byte = 8'h00;
    emit_last = 1'b0;
    do_append = 1'b0;
    do_shift  = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (in_accept) begin
          byte_d = text_byte_i;
          if (end_of_text_i) begin
            tail_d = 1'b0;
            if (count_q != '0) begin
              st_d = ST_FLUSH;
            end
          end else if (text_byte_i == NEWLINE_BYTE ||
                       (len != '0 && LEN_W'(count_q) >= len)) begin
            // flush the hold row, then pass the byte
            tail_d = 1'b1;
            st_d   = (count_q != '0) ? ST_FLUSH : ST_BYTE;
          end else if (len == '0) begin
            st_d = ST_BYTE;
          end else begin
            do_append = 1'b1;
            count_d   = count_q + CntW'(1);
            st_d      = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (LEN_W'(count_q) == len && prefix_own) begin
          count_d = '0;
          ridx_d  = '0;
          st_d    = (rlen != '0) ? ST_REPL : ST_IDLE;
        end else if (prefix_own) begin
          st_d = ST_IDLE;
        end else begin
          st_d = ST_POP;
        end
      end
      ST_POP: begin
        // release the head byte until the rest is a pattern prefix again
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = cell_byte[0];
          emit_last = rest_ok;
          do_shift  = 1'b1;
          count_d   = count_q - CntW'(1);
          if (rest_ok) begin
            st_d = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = cell_byte[0];
          emit_last = (count_q == CntW'(1)) && !tail_q;
          do_shift  = 1'b1;
          count_d   = count_q - CntW'(1);
          if (count_q == CntW'(1)) begin
            st_d = tail_q ? ST_BYTE : ST_IDLE;
          end
        end
      end
      ST_BYTE: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = byte_q;
          emit_last = 1'b1;
          st_d      = ST_IDLE;
        end
      end
      ST_REPL: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = rep_q[ridx_q*8 +: 8];
          emit_last = (LEN_W'(ridx_q) == rlen - LEN_W'(1));
          ridx_d    = ridx_q + RepW'(1);
          if (emit_last) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      count_q <= '0;
      tail_q  <= 1'b0;
      ridx_q  <= '0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
      tail_q  <= tail_d;
      ridx_q  <= ridx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // Output register: load on emit, drop after the transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = out_last_q;

  // Checks
  `SFR_ASSERT(a_release_needs_bytes, clk_i, rst_ni, (st_q == ST_POP || st_q == ST_FLUSH) |-> count_q != '0)
  `SFR_ASSERT(a_repl_row_empty, clk_i, rst_ni, (st_q == ST_REPL) |-> count_q == '0)
  `SFR_ASSERT(a_check_follows_append, clk_i, rst_ni, (st_q == ST_CHECK) |-> $past(in_accept))
  `SFR_ASSERT_NEXT(a_emit_lands, clk_i, rst_ni, emit, out_valid_q && out_byte_q == $past(emit_byte))

endmodule
